/* hdl/tmbc_pkg.sv */
// Shared types and constants for the tile map box collision block
package tmbc_pkg;

    localparam int MAP_TILES_DEF   = 4096;
    localparam int TILE_PIXELS_DEF = 16;

    typedef enum logic [1:0] {
        REQ_WRITE = 2'd0,
        REQ_SET   = 2'd1,
        REQ_MOVE  = 2'd2,
        REQ_NONE  = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        REG_COLS  = 3'd0,
        REG_ROWS  = 3'd1,
        REG_BOXW  = 3'd2,
        REG_BOXH  = 3'd3,
        REG_FTIME = 3'd4,
        REG_PBIT  = 3'd5
    } t_reg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CLAMP,
        ST_XREQ,
        ST_XCHK,
        ST_YREQ,
        ST_YCHK,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [8:0]  cols;
        logic [8:0]  rows;
        logic [11:0] box_w;
        logic [11:0] box_h;
        logic [15:0] ftime;
        logic [3:0]  pbit;
    } t_cfg;

endpackage

/* hdl/tile_map_box_collision.sv */
// Top level of the tile map box collision block
// Usage:
//   Input channel (i_valid/o_ready) carries one request: a tile write, a
//   position set, a move step or none. Only a move gives an item on the output
//   channel (o_valid/i_ready) holding the new box position.
//   Configuration goes through APB; user must write it only while the block is idle, not enforced.
// Flow and throughput:
//   Write and set are taken one per cycle, back to back, while no move is in
//   work. A move with zero velocity goes straight to ST_OUT; other moves pass
//   through ST_MUL, ST_CLAMP, an x scan (ST_XREQ/ST_XCHK) and a y scan
//   (ST_YREQ/ST_YCHK) before ST_OUT, which loads the output register and raises
//   o_valid. The tile memory's single port, read once per tested tile, bounds
//   the scan. One move is in work at a time; the next item is taken from the cycle in which the result appears.
// Reset:
//   The position goes to zero and registers to their defaults; tile memory
//   is not cleared; user must read tiles only after written, not enforced.
// Stall:
//   A result waits in the output register until taken. Writes and sets are
//   still taken meanwhile; a following move holds in its last state until
//   the register is free, and the input stalls behind it.
module tile_map_box_collision #(
    parameter int MAP_TILES = tmbc_pkg::MAP_TILES_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_req_type,
    input  logic [11:0]        i_tile_addr,
    input  logic [15:0]        i_tile_word,
    input  logic [15:0]        i_start_x,
    input  logic [15:0]        i_start_y,
    input  logic signed [15:0] i_speed_x,
    input  logic signed [15:0] i_speed_y,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [15:0]        o_pos_x,
    output logic [15:0]        o_pos_y
);
    localparam int AW = $clog2(MAP_TILES);
    localparam int TS = $clog2(tmbc_pkg::TILE_PIXELS_DEF * 16);
    localparam int PW = 24;

    tmbc_pkg::t_cfg   cfg;
    tmbc_pkg::t_state r_st, n_st;

    logic [15:0]           r_bx, r_by, n_bx, n_by;
    logic signed [PW-1:0]  r_nx, r_ny, n_nx, n_ny;
    logic signed [32:0]    r_px, r_py, n_px, n_py;
    logic [8:0]            r_i, n_i, r_hi, n_hi, r_fix, n_fix;
    logic                  r_neg, n_neg;
    logic                  r_ov, n_ov;
    logic [15:0]           r_ox, r_oy, n_ox, n_oy;
    logic                  ram_we;
    logic [AW-1:0]         ram_addr;
    logic [15:0]           ram_rd;
    logic [8:0]            cols, rows;
    logic                  acc;

    tmbc_regs u_regs (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .psel(psel), .penable(penable),
        .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata), .prdata(prdata),
        .pready(pready), .o_cfg(cfg)
    );

    tmbc_tile_ram #(.MAP_TILES(MAP_TILES)) u_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_addr(ram_addr),
        .i_wdata(i_tile_word), .o_rdata(ram_rd)
    );

    assign cols    = (cfg.cols == 9'd0) ? 9'd1 : (cfg.cols > 9'd256 ? 9'd256 : cfg.cols);
    assign rows    = (cfg.rows == 9'd0) ? 9'd1 : (cfg.rows > 9'd256 ? 9'd256 : cfg.rows);
    assign o_ready = (r_st == tmbc_pkg::ST_IDLE);
    assign acc     = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_pos_x = r_ox;
    assign o_pos_y = r_oy;

    function automatic logic signed [PW-1:0] f_round(input logic signed [32:0] p);
        logic signed [32:0] q;
        q = p + 33'sd32768;
        return PW'(q >>> 16);
    endfunction

    function automatic logic signed [PW-1:0] f_edge(input logic signed [PW-1:0] v,
                                                    input logic [11:0] sz,
                                                    input logic [8:0] t);
        logic signed [PW-1:0] e, r;
        e = $signed({{(PW-9){1'b0}}, t}) <<< TS;
        if (v < 0) r = 1;
        else if (v + $signed({{(PW-12){1'b0}}, sz}) >= e)
            r = e - $signed({{(PW-12){1'b0}}, sz}) - 1;
        else r = v;
        return (r < 0) ? '0 : r;
    endfunction

    logic                 blk, in_map;
    logic [17:0]          idx;

    // tile index and blocking test for current scan point
    always_comb begin
        logic [8:0] c, r;
        if (r_st == tmbc_pkg::ST_XREQ || r_st == tmbc_pkg::ST_XCHK) begin
            c = r_fix; r = r_i;
        end else begin
            c = r_i; r = r_fix;
        end
        idx    = 18'(c) + 18'(r) * 18'(cols);
        in_map = (c < cols) && (r < rows) && (idx < 18'(MAP_TILES));
        blk    = in_map && !ram_rd[cfg.pbit];
    end

    always_comb begin
        logic signed [PW-1:0] tv, sz, ob;
        n_st = r_st; n_bx = r_bx; n_by = r_by; n_nx = r_nx; n_ny = r_ny;
        n_px = r_px; n_py = r_py; n_i = r_i; n_hi = r_hi; n_fix = r_fix;
        n_neg = r_neg; n_ov = r_ov; n_ox = r_ox; n_oy = r_oy;
        ram_we = 1'b0; ram_addr = idx[AW-1:0];
        tv = '0; sz = '0; ob = '0;
        if (r_ov && i_ready) n_ov = 1'b0;
        unique case (r_st)
            tmbc_pkg::ST_IDLE: begin
                if (acc) begin
                    unique case (tmbc_pkg::t_req'(i_req_type))
                        tmbc_pkg::REQ_WRITE: begin
                            ram_addr = AW'(i_tile_addr);
                            ram_we   = (32'(i_tile_addr) < MAP_TILES);
                        end
                        tmbc_pkg::REQ_SET: begin
                            n_bx = i_start_x; n_by = i_start_y;
                        end
                        tmbc_pkg::REQ_MOVE: begin
                            if (i_speed_x == 0 && i_speed_y == 0) begin
                                n_st = tmbc_pkg::ST_OUT;
                            end else begin
                                n_px = 33'(i_speed_x) * $signed({17'd0, cfg.ftime});
                                n_py = 33'(i_speed_y) * $signed({17'd0, cfg.ftime});
                                n_st = tmbc_pkg::ST_MUL;
                            end
                        end
                        tmbc_pkg::REQ_NONE: ;
                    endcase
                end
            end
            tmbc_pkg::ST_MUL: begin
                n_nx = $signed({8'd0, r_bx}) + f_round(r_px);
                n_ny = $signed({8'd0, r_by}) + f_round(r_py);
                n_st = tmbc_pkg::ST_CLAMP;
            end
            tmbc_pkg::ST_CLAMP: begin
                n_nx = f_edge(r_nx, cfg.box_w, cols);
                n_ny = f_edge(r_ny, cfg.box_h, rows);
                tv   = f_edge(r_nx, cfg.box_w, cols);
                ob   = $signed({8'd0, r_bx});
                n_neg = tv < ob;
                n_i  = 9'(r_by >> TS);
                n_hi = 9'((17'(r_by) + 17'(cfg.box_h)) >> TS);
                n_fix = tv < ob ? 9'(tv >>> TS)
                        : 9'((tv + $signed({12'd0, cfg.box_w})) >>> TS);
                // skip the horizontal scan when x stays put
                if (tv == ob) n_i = 9'd256;
                n_st = tmbc_pkg::ST_XREQ;
            end
            tmbc_pkg::ST_XREQ: begin
                if (r_i > r_hi || r_i >= rows) n_st = tmbc_pkg::ST_YREQ;
                else n_st = tmbc_pkg::ST_XCHK;
                if (n_st == tmbc_pkg::ST_YREQ) begin
                    ob = $signed({8'd0, r_by});
                    n_neg = r_ny < ob;
                    n_i  = 9'(r_bx >> TS);
                    n_hi = 9'((17'(r_bx) + 17'(cfg.box_w)) >> TS);
                    n_fix = r_ny < ob ? 9'(r_ny >>> TS)
                            : 9'((r_ny + $signed({12'd0, cfg.box_h})) >>> TS);
                    if (r_ny == ob) n_i = 9'd256;
                end
            end
            tmbc_pkg::ST_XCHK: begin
                if (blk) begin
                    sz = $signed({12'd0, cfg.box_w});
                    tv = $signed({15'd0, r_fix}) <<< TS;
                    if (r_neg) n_nx = tv + (PW'(1) <<< TS);
                    else begin
                        n_nx = tv - sz - 1;
                        if (tv - sz - 1 < 0) n_nx = '0;
                    end
                    n_i = 9'd256; n_hi = 9'd0;
                end else begin
                    n_i = r_i + 9'd1;
                end
                n_st = tmbc_pkg::ST_XREQ;
            end
            tmbc_pkg::ST_YREQ: begin
                if (r_i > r_hi || r_i >= cols) n_st = tmbc_pkg::ST_OUT;
                else n_st = tmbc_pkg::ST_YCHK;
                if (n_st == tmbc_pkg::ST_OUT) begin
                    n_bx = r_nx < 0 ? 16'd0 : (r_nx > 65535 ? 16'hFFFF : r_nx[15:0]);
                    n_by = r_ny < 0 ? 16'd0 : (r_ny > 65535 ? 16'hFFFF : r_ny[15:0]);
                end
            end
            tmbc_pkg::ST_YCHK: begin
                if (blk) begin
                    sz = $signed({12'd0, cfg.box_h});
                    tv = $signed({15'd0, r_fix}) <<< TS;
                    if (r_neg) n_ny = tv + (PW'(1) <<< TS);
                    else begin
                        n_ny = tv - sz - 1;
                        if (tv - sz - 1 < 0) n_ny = '0;
                    end
                    n_i = 9'd256; n_hi = 9'd0;
                end else begin
                    n_i = r_i + 9'd1;
                end
                n_st = tmbc_pkg::ST_YREQ;
            end
            tmbc_pkg::ST_OUT: begin
                if (!r_ov || i_ready) begin
                    n_ov = 1'b1; n_ox = r_bx; n_oy = r_by;
                    n_st = tmbc_pkg::ST_IDLE;
                end
            end
            default: n_st = tmbc_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= tmbc_pkg::ST_IDLE;
            r_ov <= 1'b0;
            r_bx <= '0;
            r_by <= '0;
        end else begin
            r_st <= n_st;
            r_ov <= n_ov;
            r_bx <= n_bx;
            r_by <= n_by;
        end
    end

    always_ff @(posedge i_clk) begin
        r_nx <= n_nx; r_ny <= n_ny; r_px <= n_px; r_py <= n_py;
        r_i <= n_i; r_hi <= n_hi; r_fix <= n_fix; r_neg <= n_neg;
        r_ox <= n_ox; r_oy <= n_oy;
    end
endmodule

/* hdl/tmbc_regs.sv */
// APB configuration registers
module tmbc_regs (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [4:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready,
    output tmbc_pkg::t_cfg   o_cfg
);
    tmbc_pkg::t_cfg r_cfg;
    tmbc_pkg::t_reg w_idx;

    assign w_idx  = tmbc_pkg::t_reg'(paddr[4:2]);
    assign pready = 1'b1;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cols  <= 9'd64;
            r_cfg.rows  <= 9'd64;
            r_cfg.box_w <= 12'd256;
            r_cfg.box_h <= 12'd256;
            r_cfg.ftime <= 16'd1092;
            r_cfg.pbit  <= 4'd0;
        end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
            case (w_idx)
                tmbc_pkg::REG_COLS:  r_cfg.cols  <= pwdata[8:0];
                tmbc_pkg::REG_ROWS:  r_cfg.rows  <= pwdata[8:0];
                tmbc_pkg::REG_BOXW:  r_cfg.box_w <= pwdata[11:0];
                tmbc_pkg::REG_BOXH:  r_cfg.box_h <= pwdata[11:0];
                tmbc_pkg::REG_FTIME: r_cfg.ftime <= pwdata[15:0];
                tmbc_pkg::REG_PBIT:  r_cfg.pbit  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        if (paddr[1:0] == 2'b00) begin
            case (w_idx)
                tmbc_pkg::REG_COLS:  prdata = {23'd0, r_cfg.cols};
                tmbc_pkg::REG_ROWS:  prdata = {23'd0, r_cfg.rows};
                tmbc_pkg::REG_BOXW:  prdata = {20'd0, r_cfg.box_w};
                tmbc_pkg::REG_BOXH:  prdata = {20'd0, r_cfg.box_h};
                tmbc_pkg::REG_FTIME: prdata = {16'd0, r_cfg.ftime};
                tmbc_pkg::REG_PBIT:  prdata = {28'd0, r_cfg.pbit};
                default:             prdata = 32'd0;
            endcase
        end
    end
endmodule

/* hdl/tmbc_tile_ram.sv */
// Tile word memory, one port, registered read
module tmbc_tile_ram #(
    parameter int MAP_TILES = tmbc_pkg::MAP_TILES_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [$clog2(MAP_TILES)-1:0] i_addr,
    input  logic [15:0]                  i_wdata,
    output logic [15:0]                  o_rdata
);
    logic [15:0] r_mem [MAP_TILES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end
endmodule

/* tb/sv/tb_top.sv */
// Self-checking testbench for the tile map box collision block
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  NTILES    = tmbc_pkg::MAP_TILES_DEF;
    localparam int  NFILL     = 256;
    localparam longint TSIZE  = tmbc_pkg::TILE_PIXELS_DEF * 16;
    localparam longint CYCLE_LIMIT = 3000000;
    localparam int  SETTLE    = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [1:0]  i_req_type = '0;
    logic [11:0] i_tile_addr = '0;
    logic [15:0] i_tile_word = '0, i_start_x = '0, i_start_y = '0;
    logic signed [15:0] i_speed_x = '0, i_speed_y = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [15:0] o_pos_x, o_pos_y;

    tile_map_box_collision dut (.*);

    always #5 i_clk = ~i_clk;

    typedef struct packed {
        logic [15:0] x;
        logic [15:0] y;
    } t_pos;

    logic [15:0]    tile_mirror [NTILES];
    logic [15:0]    cur_x, cur_y;
    tmbc_pkg::t_cfg cfg;
    t_pos           pos_expected [$];

    int  send_idle_pct, recv_stall_pct, hold_cycles;
    int  fails, moves_sent, items_sent, results_seen;
    longint cycles;

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    always @(negedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            results_seen++;
            if (pos_expected.size() == 0) begin
                $error("unexpected result x=%0d y=%0d", o_pos_x, o_pos_y);
                fails++;
            end else begin
                t_pos e;
                e = pos_expected.pop_front();
                if (o_pos_x !== e.x) begin
                    $error("pos_x expected %0d actual %0d", e.x, o_pos_x);
                    fails++;
                end
                if (o_pos_y !== e.y) begin
                    $error("pos_y expected %0d actual %0d", e.y, o_pos_y);
                    fails++;
                end
            end
        end
    end

    function automatic longint tiles_of(logic [8:0] v);
        if (v < 1) return 1;
        if (v > 256) return 256;
        return v;
    endfunction

    function automatic longint scaled(logic signed [15:0] spd);
        longint p;
        p = longint'(spd) * longint'(cfg.ftime) + 32768;
        return p >>> 16;
    endfunction

    function automatic longint clamp_edge(longint v, longint sz, longint n);
        longint e;
        e = n * TSIZE;
        if (v < 0) v = 1;
        else if (v + sz >= e) v = e - sz - 1;
        return (v < 0) ? 0 : v;
    endfunction

    function automatic bit is_solid(longint c, longint r, longint nc, longint nr);
        longint idx;
        if (c < 0 || r < 0 || c >= nc || r >= nr) return 0;
        idx = c + r * nc;
        if (idx >= NTILES) return 0;
        return tile_mirror[idx][cfg.pbit] == 1'b0;
    endfunction

    function automatic longint sat16(longint v);
        if (v < 0) return 0;
        if (v > 65535) return 65535;
        return v;
    endfunction

    function automatic t_pos predict_move(logic signed [15:0] sx, logic signed [15:0] sy);
        longint nc, nr, w, h, ox, oy, nx, ny, c, r;
        t_pos p;
        if (sx == 0 && sy == 0) begin
            p.x = cur_x;
            p.y = cur_y;
            return p;
        end
        nc = tiles_of(cfg.cols);
        nr = tiles_of(cfg.rows);
        w = cfg.box_w;
        h = cfg.box_h;
        ox = cur_x;
        oy = cur_y;
        nx = clamp_edge(ox + scaled(sx), w, nc);
        ny = clamp_edge(oy + scaled(sy), h, nr);
        if (nx != ox) begin
            c = (nx < ox) ? nx / TSIZE : (nx + w) / TSIZE;
            for (longint i = oy / TSIZE; i <= (oy + h) / TSIZE && i < nr; i++) begin
                if (is_solid(c, i, nc, nr)) begin
                    if (nx < ox) nx = (c + 1) * TSIZE;
                    else begin
                        nx = c * TSIZE - w - 1;
                        if (nx < 0) nx = 0;
                    end
                    break;
                end
            end
        end
        if (ny != oy) begin
            r = (ny < oy) ? ny / TSIZE : (ny + h) / TSIZE;
            for (longint i = ox / TSIZE; i <= (ox + w) / TSIZE && i < nc; i++) begin
                if (is_solid(i, r, nc, nr)) begin
                    if (ny < oy) ny = (r + 1) * TSIZE;
                    else begin
                        ny = r * TSIZE - h - 1;
                        if (ny < 0) ny = 0;
                    end
                    break;
                end
            end
        end
        p.x = sat16(nx);
        p.y = sat16(ny);
        return p;
    endfunction

    task automatic send_item(tmbc_pkg::t_req req, logic [11:0] addr, logic [15:0] word,
                             logic [15:0] sx, logic [15:0] sy,
                             logic signed [15:0] vx, logic signed [15:0] vy);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_req_type = req;
        i_tile_addr = addr;
        i_tile_word = word;
        i_start_x = sx;
        i_start_y = sy;
        i_speed_x = vx;
        i_speed_y = vy;
        i_valid = 1'b1;
        while (!o_ready) @(negedge i_clk);
        @(posedge i_clk);
        items_sent++;
        case (req)
            tmbc_pkg::REQ_WRITE: tile_mirror[addr] = word;
            tmbc_pkg::REQ_SET: begin
                cur_x = sx;
                cur_y = sy;
            end
            tmbc_pkg::REQ_MOVE: begin
                t_pos p;
                p = predict_move(vx, vy);
                cur_x = p.x;
                cur_y = p.y;
                pos_expected.push_back(p);
                moves_sent++;
            end
            default: ;
        endcase
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pos_expected.size() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic write_reg(tmbc_pkg::t_reg idx, logic [31:0] val);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = 5'(idx) << 2;
        pwdata = val;
        @(negedge i_clk);
        penable = 1'b1;
        @(negedge i_clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            tmbc_pkg::REG_COLS:  cfg.cols = val[8:0];
            tmbc_pkg::REG_ROWS:  cfg.rows = val[8:0];
            tmbc_pkg::REG_BOXW:  cfg.box_w = val[11:0];
            tmbc_pkg::REG_BOXH:  cfg.box_h = val[11:0];
            tmbc_pkg::REG_FTIME: cfg.ftime = val[15:0];
            tmbc_pkg::REG_PBIT:  cfg.pbit = val[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(int nc, int nr, int bw, int bh, int ft, int pb);
        wait_drained();
        write_reg(tmbc_pkg::REG_COLS, nc);
        write_reg(tmbc_pkg::REG_ROWS, nr);
        write_reg(tmbc_pkg::REG_BOXW, bw);
        write_reg(tmbc_pkg::REG_BOXH, bh);
        write_reg(tmbc_pkg::REG_FTIME, ft);
        write_reg(tmbc_pkg::REG_PBIT, pb);
    endtask

    task automatic move(logic signed [15:0] vx, logic signed [15:0] vy);
        send_item(tmbc_pkg::REQ_MOVE, '0, '0, '0, '0, vx, vy);
    endtask

    task automatic place(logic [15:0] x, logic [15:0] y);
        send_item(tmbc_pkg::REQ_SET, '0, '0, x, y, '0, '0);
    endtask

    // every map used below spans at most NFILL tiles
    task automatic test_fill_map();
        for (int a = 0; a < NFILL; a++)
            send_item(tmbc_pkg::REQ_WRITE, a[11:0], 16'($urandom), '0, '0, '0, '0);
    endtask

    task automatic test_directed();
        move(0, 0);
        place(16'h0800, 16'h0800);
        move(16'sh7fff, 16'sh7fff);
        move(-16'sh8000, -16'sh8000);
        move(0, 0);
        place(16'hffff, 16'hffff);
        move(0, 0);
        move(16'sh0100, 0);
        place(0, 0);
        move(-16'sh0400, 16'sh0400);
        send_item(tmbc_pkg::REQ_NONE, 12'hfff, 16'hffff, 16'hffff, 16'hffff, -1, -1);
        send_item(tmbc_pkg::REQ_WRITE, 12'h041, 16'h0000, '0, '0, '0, '0);
        send_item(tmbc_pkg::REQ_WRITE, 12'h042, 16'hffff, '0, '0, '0, '0);
        place(16'h0100, 16'h0100);
        move(16'sh7fff, 0);
        place(16'h0300, 16'h0100);
        move(-16'sh8000, 0);
        place(16'h0100, 16'h0300);
        move(0, -16'sh8000);
        move(16'sh0001, -16'sh0001);
        move(-16'sh0001, 16'sh0001);
    endtask

    function automatic logic signed [15:0] rand_speed();
        case ($urandom_range(3))
            0: return 16'($urandom);
            1: return 16'($urandom_range(1024)) - 16'sd512;
            2: return $urandom_range(1) ? 16'sh7fff : -16'sh8000;
            default: return 16'($urandom_range(64)) - 16'sd32;
        endcase
    endfunction

    task automatic random_items(int n);
        int lim;
        lim = tiles_of(cfg.cols) * TSIZE;
        for (int k = 0; k < n; k++) begin
            case ($urandom_range(19))
                0: send_item(tmbc_pkg::REQ_WRITE, 12'($urandom), 16'($urandom),
                             '0, '0, '0, '0);
                1: send_item(tmbc_pkg::REQ_NONE, 12'($urandom), 16'($urandom),
                             16'($urandom), 16'($urandom), 16'($urandom),
                             16'($urandom));
                2: place(16'($urandom), 16'($urandom));
                3, 4: place(16'($urandom_range(lim - 1)), 16'($urandom_range(lim - 1)));
                5: move(0, 0);
                default: move(rand_speed(), rand_speed());
            endcase
        end
    endtask

    task automatic test_backpressure();
        wait_drained();
        hold_cycles = 400;
        for (int k = 0; k < 10; k++) move(rand_speed(), rand_speed());
        wait_drained();
    endtask

    task automatic run_phase(int sp, int rp, int n);
        wait_drained();
        send_idle_pct = sp;
        recv_stall_pct = rp;
        random_items(n);
    endtask

    initial begin
        cfg = '{cols: 64, rows: 64, box_w: 256, box_h: 256, ftime: 1092, pbit: 0};
        cur_x = '0;
        cur_y = '0;
        cycles = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_cycles = 0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_fill_map();
        set_config(16, 16, 256, 256, 1092, 0);
        test_directed();
        run_phase(0, 0, 70);
        run_phase(86, 0, 40);
        test_backpressure();

        set_config(1, 1, 0, 0, 65535, 15);
        test_directed();
        run_phase(0, 86, 40);
        set_config(256, 1, 4095, 4095, 0, 0);
        run_phase(8, 8, 40);
        set_config(0, 511, 100, 3000, 65535, 7);
        run_phase(0, 0, 55);
        set_config(16, 8, 200, 40, 8000, 3);
        run_phase(86, 86, 30);
        run_phase(0, 0, 55);
        set_config(3, 85, 4095, 0, 30000, 15);
        run_phase(0, 86, 40);
        set_config(16, 16, 256, 256, 1092, 0);
        run_phase(8, 8, 80);
        test_backpressure();
        set_config(8, 32, 17, 500, 65535, 9);
        run_phase(0, 0, 70);

        wait_drained();
        $display("covered %0d items (%0d moves, %0d results) over several map shapes",
                 items_sent, moves_sent, results_seen);
        $display("with free flow, sender gaps, receiver stalls and long hold-offs");
        if (fails == 0 && pos_expected.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule

/* sim.f */
hdl/tmbc_pkg.sv
hdl/tmbc_regs.sv
hdl/tmbc_tile_ram.sv
hdl/tile_map_box_collision.sv
tb/sv/tb_top.sv
